[rtl/stack_bytecode_executor_core_defines.svh]
// assertion macros for the stack bytecode executor
`ifndef STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SBE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/sbe_pkg.sv]
// shared constants and types for the stack bytecode executor
package sbe_pkg;
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RESTART = 2'd1;
	localparam logic [1:0] MODE_EXEC = 2'd2;

	localparam logic [7:0] OP_LOAD = 8'd0;
	localparam logic [7:0] OP_STORE = 8'd1;
	localparam logic [7:0] OP_PUSH = 8'd2;
	localparam logic [7:0] OP_DUP = 8'd3;
	localparam logic [7:0] OP_POP = 8'd4;
	localparam logic [7:0] OP_ADD = 8'd5;
	localparam logic [7:0] OP_SUB = 8'd6;
	localparam logic [7:0] OP_MUL = 8'd7;
	localparam logic [7:0] OP_MOD = 8'd8;
	localparam logic [7:0] OP_DIV = 8'd9;
	localparam logic [7:0] OP_GOTO = 8'd10;
	localparam logic [7:0] OP_BZ = 8'd11;
	localparam logic [7:0] OP_BNZ = 8'd12;
	localparam logic [7:0] OP_BNEG = 8'd13;
	localparam logic [7:0] OP_RET = 8'd14;
	localparam logic [7:0] OP_PRINT = 8'd15;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_DIV0 = 3'd1;
	localparam logic [2:0] ERR_OVF = 3'd2;
	localparam logic [2:0] ERR_UNF = 3'd3;
	localparam logic [2:0] ERR_PC = 3'd4;

	typedef struct packed {
		logic start;
		logic is_div;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;
endpackage

[rtl/sbe_divider.sv]
// iterative signed divider, one quotient bit per cycle
module sbe_divider
	import sbe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] num_q, den_q, quo_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q, rneg_q, done_q;
	logic [32:0] shifted, diff;

	assign shifted = {rem_q[31:0], num_q[31]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.a[31] ? (32'd0 - req.a) : req.a;
			den_q <= req.b[31] ? (32'd0 - req.b) : req.b;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= req.a[31] ^ req.b[31];
			rneg_q <= req.a[31];
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = neg_q ? (32'd0 - quo_q) : quo_q;
	assign rsp.rem = rneg_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
endmodule

[rtl/stack_bytecode_executor_core.sv]
// Stack bytecode executor. Each transfer on the input side is one step, whose result is
// then offered on the output side: mode 0 writes a code byte, mode 1 restarts (clearing
// variables one per cycle), mode 2 executes one instruction unless halted, and mode 3
// does nothing. An instruction passes through the opcode read, operand read and two stack
// reads from single-port memories, then execute and write back; dup adds a second
// write-back. Mod and div go from execute through the shared one-bit-per-cycle divider
// to write back. Faulting instructions and return end after execute. The result is held
// in an output register until taken; no new step is accepted meanwhile.
module stack_bytecode_executor_core
	import sbe_pkg::*;
#(
	parameter int CODE_DEPTH = 1024,
	parameter int STACK_DEPTH = 1024,
	parameter int NUM_VARS = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [9:0]         code_addr,
	input  logic signed [7:0]  code_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic               halted,
	output logic [2:0]         error_code,
	output logic [9:0]         program_counter
);
	`include "stack_bytecode_executor_core_defines.svh"

	localparam int CW = $clog2(CODE_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int DW = SW + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OP = 4'd1;
	localparam logic [3:0] ST_ARG = 4'd2;
	localparam logic [3:0] ST_RDB = 4'd3;
	localparam logic [3:0] ST_RDA = 4'd4;
	localparam logic [3:0] ST_EXEC = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_WB = 4'd7;
	localparam logic [3:0] ST_CLR = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;
	localparam logic [3:0] ST_WB2 = 4'd10;

	logic [3:0] state_q;
	logic [7:0] code_mem [CODE_DEPTH];
	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] var_q [NUM_VARS];
	logic [7:0] crd_q;
	logic [31:0] srd_q;
	logic [CW-1:0] pc_q;
	logic [DW-1:0] sp_q;
	logic halt_q;
	logic [2:0] err_q;
	logic [7:0] op_q;
	logic signed [7:0] arg_q;
	logic [31:0] b_q, res_q;
	logic [VW-1:0] clr_q;
	logic pv_q;
	logic [31:0] pval_q;

	logic [CW-1:0] caddr;
	logic cwe;
	logic [SW-1:0] saddr;
	logic swe;
	logic [31:0] swd;
	div_req_t dreq;
	div_rsp_t drsp;

	logic has_arg;
	logic [1:0] pops, pushes;
	logic [DW+1:0] newd;
	logic signed [CW+9:0] npc;
	logic take;
	logic arg_ok;
	logic [31:0] varval;

	sbe_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		has_arg = (op_q <= OP_PUSH) || (op_q >= OP_GOTO && op_q <= OP_BNEG);
		pops = 2'd0;
		pushes = 2'd0;
		unique case (op_q)
			OP_LOAD, OP_PUSH: pushes = 2'd1;
			OP_STORE, OP_POP, OP_BZ, OP_BNZ, OP_BNEG, OP_PRINT: pops = 2'd1;
			OP_DUP: begin
				pops = 2'd1;
				pushes = 2'd2;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_DIV: begin
				pops = 2'd2;
				pushes = 2'd1;
			end
			default: ;
		endcase
		newd = {2'b0, sp_q} - {{DW{1'b0}}, pops} + {{DW{1'b0}}, pushes};
		unique case (op_q)
			OP_GOTO: take = 1'b1;
			OP_BZ: take = (b_q == 32'd0);
			OP_BNZ: take = (b_q != 32'd0);
			OP_BNEG: take = b_q[31];
			default: take = 1'b0;
		endcase
		if (take)
			npc = (CW+10)'($signed({10'd0, pc_q}) + 1 + arg_q);
		else
			npc = (CW+10)'($signed({10'd0, pc_q}) + (has_arg ? 2 : 1));
		arg_ok = !arg_q[7] && ({24'd0, arg_q} < NUM_VARS);
		varval = arg_ok ? var_q[arg_q[VW-1:0]] : 32'd0;
	end

	always_comb begin
		caddr = pc_q;
		cwe = 1'b0;
		saddr = sp_q[SW-1:0] - SW'(1);
		swe = 1'b0;
		swd = res_q;
		dreq = '0;
		dreq.a = srd_q;
		dreq.b = b_q;
		unique case (state_q)
			ST_IDLE: begin
				caddr = code_addr[CW-1:0];
				cwe = in_valid && mode == MODE_WRITE && ({6'd0, code_addr} < CODE_DEPTH);
			end
			ST_ARG: caddr = pc_q + CW'(1);
			ST_RDA: saddr = sp_q[SW-1:0] - SW'(2);
			ST_EXEC: dreq.start = (op_q == OP_MOD || op_q == OP_DIV) && !(
				(pc_q + 1 >= CODE_DEPTH && has_arg) || sp_q < pops || b_q == 32'd0);
			ST_WB: begin
				saddr = newd[SW-1:0] - SW'(1);
				swe = (pushes != 2'd0) && op_q != OP_DUP;
				if (op_q == OP_DUP) begin
					saddr = newd[SW-1:0] - SW'(2);
					swe = 1'b1;
					swd = b_q;
				end
			end
			ST_WB2: begin
				saddr = sp_q[SW-1:0] - SW'(1);
				swe = 1'b1;
				swd = b_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cwe)
			code_mem[caddr] <= code_byte;
		crd_q <= code_mem[caddr];
	end

	always_ff @(posedge clk) begin
		if (swe)
			stack_mem[saddr] <= swd;
		srd_q <= stack_mem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			sp_q <= '0;
			halt_q <= 1'b0;
			err_q <= ERR_NONE;
			clr_q <= '0;
			pv_q <= 1'b0;
			for (int i = 0; i < NUM_VARS; i++)
				var_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					pv_q <= 1'b0;
					if (mode == MODE_RESTART) begin
						pc_q <= '0;
						sp_q <= '0;
						halt_q <= 1'b0;
						err_q <= ERR_NONE;
						clr_q <= '0;
						state_q <= ST_CLR;
					end else if (mode == MODE_EXEC && !halt_q)
						state_q <= ST_OP;
					else
						state_q <= ST_OUT;
				end
				ST_CLR: begin
					var_q[clr_q] <= '0;
					clr_q <= clr_q + VW'(1);
					if (32'(clr_q) == NUM_VARS - 1)
						state_q <= ST_OUT;
				end
				ST_OP: state_q <= ST_ARG;
				ST_ARG: begin
					op_q <= crd_q;
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					arg_q <= crd_q;
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					b_q <= srd_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					priority if (has_arg && 32'(pc_q) + 1 >= CODE_DEPTH) begin
						halt_q <= 1'b1;
						err_q <= ERR_PC;
						state_q <= ST_OUT;
					end else if (sp_q < DW'(pops)) begin
						halt_q <= 1'b1;
						err_q <= ERR_UNF;
						state_q <= ST_OUT;
					end else if ((op_q == OP_MOD || op_q == OP_DIV) && b_q == 32'd0) begin
						halt_q <= 1'b1;
						err_q <= ERR_DIV0;
						state_q <= ST_OUT;
					end else if (32'(newd) >= STACK_DEPTH) begin
						halt_q <= 1'b1;
						err_q <= ERR_OVF;
						state_q <= ST_OUT;
					end else if (op_q == OP_RET) begin
						halt_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (npc < 0 || npc >= CODE_DEPTH) begin
						halt_q <= 1'b1;
						err_q <= ERR_PC;
						state_q <= ST_OUT;
					end else if (op_q == OP_MOD || op_q == OP_DIV)
						state_q <= ST_DIV;
					else begin
						unique case (op_q)
							OP_LOAD: res_q <= varval;
							OP_PUSH: res_q <= {{24{arg_q[7]}}, arg_q};
							OP_ADD: res_q <= srd_q + b_q;
							OP_SUB: res_q <= srd_q - b_q;
							OP_MUL: res_q <= srd_q * b_q;
							default: res_q <= b_q;
						endcase
						state_q <= ST_WB;
					end
				end
				ST_DIV: if (drsp.done) begin
					res_q <= (op_q == OP_DIV) ? drsp.quo : drsp.rem;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (op_q == OP_STORE && arg_ok)
						var_q[arg_q[VW-1:0]] <= b_q;
					if (op_q == OP_PRINT) begin
						pv_q <= 1'b1;
						pval_q <= b_q;
					end
					sp_q <= newd[DW-1:0];
					pc_q <= npc[CW-1:0];
					state_q <= (op_q == OP_DUP) ? ST_WB2 : ST_OUT;
				end
				ST_WB2: state_q <= ST_OUT;
				ST_OUT: if (out_ready)
					state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign print_valid = pv_q;
	assign print_value = pv_q ? pval_q : 32'd0;
	assign halted = halt_q;
	assign error_code = err_q;
	assign program_counter = 10'(pc_q);

	`SBE_ASSERT_IMP(a_err_halts, err_q != ERR_NONE, halt_q, "error without halt")
	`SBE_ASSERT_IMP(a_one_side, out_valid, !in_ready, "input open while result pending")
	`SBE_ASSERT_IMP(a_depth, 1'b1, 32'(sp_q) < STACK_DEPTH, "stack depth out of range")
	`SBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pc_q),
		"result dropped")
endmodule

[tb/stack_bytecode_executor_core_test.sv]
// self-checking testbench for the stack bytecode executor core
`timescale 1ns / 1ps
module stack_bytecode_executor_core_test;
	import sbe_pkg::*;

	localparam int CODE_DEPTH = 1024;
	localparam int STACK_DEPTH = 1024;
	localparam int NUM_VARS = 26;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1750;
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	typedef struct packed {
		logic        print_valid;
		logic [31:0] print_value;
		logic        halted;
		logic [2:0]  error_code;
		logic [9:0]  program_counter;
	} step_status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         mode = MODE_WRITE;
	logic [9:0]         code_addr = '0;
	logic signed [7:0]  code_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               halted;
	logic [2:0]         error_code;
	logic [9:0]         program_counter;

	stack_bytecode_executor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .code_addr(code_addr), .code_byte(code_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.print_valid(print_valid), .print_value(print_value), .halted(halted),
		.error_code(error_code), .program_counter(program_counter)
	);

	always #5 clk = ~clk;

	logic [7:0]  code_mem [CODE_DEPTH];
	bit          code_written [CODE_DEPTH];
	logic [31:0] opnd_stack [STACK_DEPTH];
	logic [31:0] var_store [NUM_VARS];
	int          pc_q;
	int          depth_q;
	bit          halt_q;
	logic [2:0]  err_q;

	step_status_t status_q [$];
	int fail_count = 0;
	int step_count = 0;
	int burst_left = 0;
	bit hold_req = 0;
	int idle_cycles = 0;

	function automatic void clear_run();
		pc_q = 0;
		depth_q = 0;
		halt_q = 0;
		err_q = ERR_NONE;
		foreach (var_store[i]) var_store[i] = '0;
	endfunction

	function automatic void raise_fault(logic [2:0] code);
		halt_q = 1;
		err_q = code;
	endfunction

	function automatic bit takes_operand(logic [7:0] op);
		return op <= OP_PUSH || (op >= OP_GOTO && op <= OP_BNEG);
	endfunction

	function automatic void run_instr(output bit printed, output logic [31:0] pval);
		logic [7:0] op;
		logic [31:0] a, b, res;
		int arg, npc, pops, pushes;
		bit has_arg;
		printed = 0;
		pval = '0;
		a = '0;
		b = '0;
		res = '0;
		arg = 0;
		pops = 0;
		pushes = 0;
		op = code_mem[pc_q];
		has_arg = takes_operand(op);
		if (has_arg) begin
			if (pc_q + 1 >= CODE_DEPTH) begin
				raise_fault(ERR_PC);
				return;
			end
			arg = int'($signed(code_mem[pc_q + 1]));
		end
		case (op)
			OP_LOAD, OP_PUSH: pushes = 1;
			OP_STORE, OP_POP, OP_BZ, OP_BNZ, OP_BNEG, OP_PRINT: pops = 1;
			OP_DUP: begin
				pops = 1;
				pushes = 2;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_DIV: begin
				pops = 2;
				pushes = 1;
			end
			default: ;
		endcase
		if (depth_q < pops) begin
			raise_fault(ERR_UNF);
			return;
		end
		if (pops >= 1) b = opnd_stack[depth_q - 1];
		if (pops >= 2) a = opnd_stack[depth_q - 2];
		if ((op == OP_MOD || op == OP_DIV) && b == 0) begin
			raise_fault(ERR_DIV0);
			return;
		end
		if (depth_q - pops + pushes >= STACK_DEPTH) begin
			raise_fault(ERR_OVF);
			return;
		end
		npc = pc_q + (has_arg ? 2 : 1);
		case (op)
			OP_LOAD: res = (arg >= 0 && arg < NUM_VARS) ? var_store[arg] : '0;
			OP_PUSH: res = 32'(arg);
			OP_DUP: res = b;
			OP_ADD: res = a + b;
			OP_SUB: res = a - b;
			OP_MUL: res = a * b;
			OP_DIV: res = (b == 32'hFFFF_FFFF) ? 32'(0) - a : 32'($signed(a) / $signed(b));
			OP_MOD: res = (b == 32'hFFFF_FFFF) ? '0 : 32'($signed(a) % $signed(b));
			OP_GOTO: npc = pc_q + 1 + arg;
			OP_BZ: if (b == 0) npc = pc_q + 1 + arg;
			OP_BNZ: if (b != 0) npc = pc_q + 1 + arg;
			OP_BNEG: if (b[31]) npc = pc_q + 1 + arg;
			OP_RET: begin
				halt_q = 1;
				return;
			end
			default: ;
		endcase
		if (npc < 0 || npc >= CODE_DEPTH) begin
			raise_fault(ERR_PC);
			return;
		end
		if (op == OP_STORE && arg >= 0 && arg < NUM_VARS) var_store[arg] = b;
		if (op == OP_PRINT) begin
			printed = 1;
			pval = b;
		end
		depth_q -= pops;
		if (op == OP_DUP) opnd_stack[depth_q++] = b;
		if (pushes != 0) opnd_stack[depth_q++] = res;
		pc_q = npc;
	endfunction

	function automatic step_status_t predict_step(logic [1:0] m, logic [9:0] a, logic [7:0] d);
		step_status_t s;
		bit printed;
		logic [31:0] pval;
		printed = 0;
		pval = '0;
		case (m)
			MODE_WRITE: begin
				code_mem[a] = d;
				code_written[a] = 1;
			end
			MODE_RESTART: clear_run();
			MODE_EXEC: if (!halt_q) run_instr(printed, pval);
			default: ;
		endcase
		s.print_valid = printed;
		s.print_value = printed ? pval : '0;
		s.halted = halt_q;
		s.error_code = err_q;
		s.program_counter = 10'(pc_q);
		return s;
	endfunction

	task automatic send_step(logic [1:0] m, logic [9:0] a, logic [7:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		mode <= m;
		code_addr <= a;
		code_byte <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		status_q.push_back(predict_step(m, a, d));
		burst_left--;
		step_count++;
	endtask

	task automatic put_code(int addr, int b);
		send_step(MODE_WRITE, 10'(addr), 8'(b));
	endtask

	task automatic load_prog(int base, input int prog[]);
		foreach (prog[i]) put_code(base + i, prog[i]);
	endtask

	// never let the block use a code byte that was not written
	task automatic exec_one();
		if (!halt_q) begin
			if (!code_written[pc_q]) put_code(pc_q, $urandom);
			if (takes_operand(code_mem[pc_q]) && pc_q + 1 < CODE_DEPTH
					&& !code_written[pc_q + 1])
				put_code(pc_q + 1, $urandom);
		end
		send_step(MODE_EXEC, 10'($urandom), 8'($urandom));
	endtask

	task automatic run_steps(int n);
		repeat (n) exec_one();
	endtask

	task automatic restart_run();
		send_step(MODE_RESTART, 10'($urandom), 8'($urandom));
	endtask

	task automatic test_arith();
		load_prog(0, '{OP_PUSH, 127, OP_PUSH, -128, OP_ADD, OP_PRINT,
			OP_PUSH, 7, OP_PUSH, -3, OP_DIV, OP_PRINT,
			OP_PUSH, -7, OP_PUSH, 3, OP_MOD, OP_PRINT,
			OP_PUSH, -128, OP_PUSH, 127, OP_SUB, OP_DUP, OP_MUL, OP_PRINT,
			OP_PUSH, 9, OP_STORE, 25, OP_LOAD, 25, OP_LOAD, 26, OP_STORE, -1,
			OP_LOAD, -128, OP_POP, OP_PRINT, 200, OP_RET});
		restart_run();
		run_steps(34);
	endtask

	task automatic test_branches();
		load_prog(0, '{OP_PUSH, 0, OP_BZ, 1, 255, OP_PUSH, -5, OP_BNEG, 1, 16,
			OP_PUSH, 3, OP_BNZ, 2, OP_RET, 0, OP_PUSH, 0, OP_BNZ, 1,
			OP_PUSH, 1, OP_BNEG, 1, OP_GOTO, 1, 99, OP_RET});
		restart_run();
		run_steps(16);
	endtask

	task automatic test_int_min();
		load_prog(0, '{OP_PUSH, -128, OP_DUP, OP_MUL, OP_DUP, OP_MUL, OP_PUSH, 8,
			OP_MUL, OP_DUP, OP_PUSH, -1, OP_DIV, OP_PRINT, OP_PUSH, -1, OP_MOD,
			OP_PRINT, OP_RET});
		restart_run();
		run_steps(15);
	endtask

	task automatic test_faults();
		load_prog(0, '{OP_PUSH, 1, OP_PUSH, 0, OP_DIV});
		restart_run();
		run_steps(4);
		put_code(0, OP_ADD);
		restart_run();
		run_steps(2);
		load_prog(0, '{OP_GOTO, -128});
		restart_run();
		run_steps(1);
		// hop up to the last address, then fall off the end
		for (int i = 0; i < 7; i++) load_prog(i * 128, '{OP_GOTO, 127});
		load_prog(896, '{OP_GOTO, 126});
		put_code(1023, 16);
		restart_run();
		run_steps(10);
		put_code(1023, OP_PUSH);
		restart_run();
		run_steps(9);
		send_step(MODE_IGNORED, 10'h3FF, 8'hFF);
	endtask

	// one push, then a loop of dups until a dup overflows the stack
	task automatic test_stack_full();
		load_prog(0, '{OP_PUSH, 1, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP,
			OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP, OP_DUP,
			OP_DUP, OP_GOTO, -17});
		restart_run();
		while (!halt_q) exec_one();
		exec_one();
	endtask

	task automatic test_backpressure();
		restart_run();
		hold_req = 1;
		run_steps(6);
		while (hold_req) @(posedge clk);
	endtask

	task automatic test_random();
		int len, op, steps;
		while (step_count < RANDOM_ITEMS) begin
			len = $urandom_range(8, 40);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					put_code(i, $urandom);
				end else begin
					op = $urandom_range(0, 16);
					put_code(i, op);
					if (takes_operand(8'(op)) && i + 1 < len) begin
						i++;
						if (op <= OP_STORE) put_code(i, $urandom_range(0, 29));
						else if (op == OP_PUSH) put_code(i, $urandom);
						else put_code(i, $urandom_range(0, 12) - 6);
					end
				end
			end
			restart_run();
			steps = $urandom_range(10, 60);
			for (int k = 0; k < steps; k++) begin
				case ($urandom_range(0, 19))
					0: put_code($urandom_range(0, CODE_DEPTH - 1), $urandom);
					1: send_step(MODE_IGNORED, 10'($urandom), 8'($urandom));
					default: exec_one();
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				automatic step_status_t e = status_q.pop_front();
				if (print_valid !== e.print_valid) begin
					$error("print_valid exp %0d got %0d", e.print_valid, print_valid);
					fail_count++;
				end
				if (print_value !== e.print_value) begin
					$error("print_value exp %0d got %0d", $signed(e.print_value),
						print_value);
					fail_count++;
				end
				if (halted !== e.halted) begin
					$error("halted exp %0d got %0d", e.halted, halted);
					fail_count++;
				end
				if (error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, error_code);
					fail_count++;
				end
				if (program_counter !== e.program_counter) begin
					$error("program_counter exp %0d got %0d", e.program_counter,
						program_counter);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				phase++;
				if ((phase / 64) % 3 == 0) out_ready <= 1'b1;
				else out_ready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clear_run();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arith();
		test_branches();
		test_int_min();
		test_faults();
		test_backpressure();
		test_stack_full();
		test_random();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/sbe_pkg.sv
rtl/sbe_divider.sv
rtl/stack_bytecode_executor_core.sv
tb/stack_bytecode_executor_core_test.sv
